FILE: hdl/brlg_pkg.sv
package brlg_pkg;

   // Frame buffer dimensions are 12 bits wide.
   localparam int DIM_BITS   = 12;
   localparam int INDEX_BITS = 22;

   localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RESET  = DIM_BITS'(700);
   localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RESET = DIM_BITS'(700);

   localparam int CSR_INDEX_BITS = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

endpackage

FILE: hdl/brlg_if.sv
// Command channel: one beat is a start or a step command.
interface brlg_req_if import brlg_pkg::*; #(parameter int COORD_BITS = 12);
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (output valid, command, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, command, start_x, start_y, end_x, end_y, output ready);
endinterface

// Pixel channel: one beat is one pixel of the line.
interface brlg_rsp_if import brlg_pkg::*; #(parameter int COORD_BITS = 12);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic                         on_screen;
   logic [INDEX_BITS-1:0]        buffer_index;
   logic                         last;

   modport source (output valid, pixel_x, pixel_y, on_screen, buffer_index, last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, on_screen, buffer_index, last, output ready);
endinterface

FILE: hdl/bresenham_line_pixel_generator.sv
// A pixel is registered in stage one when its command beat is taken, then in the output
// register that drives the rsp channel. Throughput: one command beat per cycle while the
// rsp channel does not stall; every start and every step of a running line yields one
// pixel beat, a step with no line in progress none. Reset (synchronous, active high)
// drops a line in progress, empties both stages and sets screen width and height to 700.
module bresenham_line_pixel_generator import brlg_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   brlg_req_if.sink                  req_bus,
   brlg_rsp_if.source                rsp_bus,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DIM_BITS-1:0]       csr_wdata
);

   // Endpoint differences need one bit more than a coordinate. The error term
   // stays within minus twice the major delta and plus twice the minor delta,
   // so three extra bits cover it with margin for the intermediate sums.
   localparam int D_BITS   = COORD_BITS + 1;
   localparam int E_BITS   = COORD_BITS + 3;
   localparam int CMP_BITS = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
   localparam int PROD_BITS = 2 * DIM_BITS;

   // Handshake and pipeline flow control. The line state advances when a
   // command beat is taken; stage one holds the raw pixel and stage two the
   // clipped pixel with its frame buffer index.
   logic out_advance;
   logic p1_advance;
   logic req_accept;

   // Line state.
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic signed [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0] major_end_ff, major_end_in;
   logic [E_BITS-1:0]            error_ff, error_in;
   logic [COORD_BITS-1:0]        major_delta_ff, major_delta_in;
   logic [COORD_BITS-1:0]        minor_delta_ff, minor_delta_in;
   logic                         steep_ff, steep_in;
   logic                         minor_up_ff, minor_up_in;
   logic                         active_ff, active_in;

   // Stage one: the pixel just produced by the line state.
   logic                         p1_valid_ff;
   logic signed [COORD_BITS-1:0] p1_x_ff;
   logic signed [COORD_BITS-1:0] p1_y_ff;
   logic                         p1_last_ff;

   // Stage two: output register.
   logic                         out_valid_ff;
   logic signed [COORD_BITS-1:0] out_x_ff;
   logic signed [COORD_BITS-1:0] out_y_ff;
   logic                         out_on_ff;
   logic [INDEX_BITS-1:0]        out_index_ff;
   logic                         out_last_ff;

   // Configuration registers.
   logic [DIM_BITS-1:0] screen_width_ff;
   logic [DIM_BITS-1:0] screen_height_ff;

   // Per-beat line logic.
   logic                         emit;
   logic                         is_last;
   logic signed [D_BITS-1:0]     dx;
   logic signed [D_BITS-1:0]     dy;
   logic [D_BITS-1:0]            adx_full;
   logic [D_BITS-1:0]            ady_full;
   logic [COORD_BITS-1:0]        adx;
   logic [COORD_BITS-1:0]        ady;
   logic                         take_minor;
   logic [E_BITS-1:0]            step_axis;
   logic [E_BITS-1:0]            step_diag;

   // Clipping and frame buffer index.
   logic [CMP_BITS-1:0]          x_ext;
   logic [CMP_BITS-1:0]          y_ext;
   logic                         on_screen;
   logic [DIM_BITS-1:0]          row;
   logic [PROD_BITS-1:0]         prod;
   logic [PROD_BITS:0]           index_full;
   logic [INDEX_BITS-1:0]        index_clip;

   assign out_advance   = !out_valid_ff || rsp_bus.ready;
   assign p1_advance    = !p1_valid_ff || out_advance;
   assign req_bus.ready = p1_advance;
   assign req_accept    = req_bus.valid && p1_advance;

   // Endpoint differences and their magnitudes.
   always_comb begin
      dx       = D_BITS'(req_bus.end_x) - D_BITS'(req_bus.start_x);
      dy       = D_BITS'(req_bus.end_y) - D_BITS'(req_bus.start_y);
      adx_full = dx[D_BITS-1] ? D_BITS'(-dx) : D_BITS'(dx);
      ady_full = dy[D_BITS-1] ? D_BITS'(-dy) : D_BITS'(dy);
      adx      = adx_full[COORD_BITS-1:0];
      ady      = ady_full[COORD_BITS-1:0];
   end

   // Error increments for an axial move and for a diagonal move.
   assign step_axis = E_BITS'({minor_delta_ff, 1'b0});
   assign step_diag = E_BITS'({minor_delta_ff, 1'b0}) - E_BITS'({major_delta_ff, 1'b0});

   // Shallow lines move the minor coordinate when the error is not negative,
   // steep lines only when it is strictly positive.
   assign take_minor = steep_ff ? (!error_ff[E_BITS-1] && (error_ff != '0))
                                : !error_ff[E_BITS-1];

   always_comb begin
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      major_end_in   = major_end_ff;
      error_in       = error_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      steep_in       = steep_ff;
      minor_up_in    = minor_up_ff;
      active_in      = active_ff;
      emit           = 1'b0;
      is_last        = 1'b0;
      if (req_accept) begin
         unique case (req_bus.command)
            CMD_START: begin
               // A start always wins over a line still in progress. Drawing
               // begins at the endpoint with the lower major coordinate.
               steep_in    = ady > adx;
               minor_up_in = (dx[D_BITS-1] && dy[D_BITS-1]) ||
                             (!dx[D_BITS-1] && (dx != '0) && !dy[D_BITS-1] && (dy != '0));
               if (!steep_in) begin
                  major_delta_in = adx;
                  minor_delta_in = ady;
                  if (!dx[D_BITS-1]) begin
                     cur_x_in     = req_bus.start_x;
                     cur_y_in     = req_bus.start_y;
                     major_end_in = req_bus.end_x;
                  end else begin
                     cur_x_in     = req_bus.end_x;
                     cur_y_in     = req_bus.end_y;
                     major_end_in = req_bus.start_x;
                  end
                  is_last = cur_x_in >= major_end_in;
               end else begin
                  major_delta_in = ady;
                  minor_delta_in = adx;
                  if (!dy[D_BITS-1]) begin
                     cur_x_in     = req_bus.start_x;
                     cur_y_in     = req_bus.start_y;
                     major_end_in = req_bus.end_y;
                  end else begin
                     cur_x_in     = req_bus.end_x;
                     cur_y_in     = req_bus.end_y;
                     major_end_in = req_bus.start_y;
                  end
                  is_last = cur_y_in >= major_end_in;
               end
               error_in  = E_BITS'({minor_delta_in, 1'b0}) - E_BITS'(major_delta_in);
               active_in = !is_last;
               emit      = 1'b1;
            end
            CMD_STEP: begin
               // A step with no line in progress is dropped without a pixel.
               if (active_ff) begin
                  if (!steep_ff) begin
                     cur_x_in = cur_x_ff + COORD_BITS'(1);
                     if (take_minor) begin
                        cur_y_in = minor_up_ff ? cur_y_ff + COORD_BITS'(1)
                                               : cur_y_ff - COORD_BITS'(1);
                     end
                     is_last = cur_x_in >= major_end_ff;
                  end else begin
                     cur_y_in = cur_y_ff + COORD_BITS'(1);
                     if (take_minor) begin
                        cur_x_in = minor_up_ff ? cur_x_ff + COORD_BITS'(1)
                                               : cur_x_ff - COORD_BITS'(1);
                     end
                     is_last = cur_y_in >= major_end_ff;
                  end
                  error_in  = error_ff + (take_minor ? step_diag : step_axis);
                  active_in = !is_last;
                  emit      = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Clipping against the screen and the bottom-up frame buffer index. The
   // index is only meaningful on screen, where y is below the height and so
   // fits the dimension width.
   always_comb begin
      x_ext      = CMP_BITS'($unsigned(p1_x_ff));
      y_ext      = CMP_BITS'($unsigned(p1_y_ff));
      on_screen  = !p1_x_ff[COORD_BITS-1] && !p1_y_ff[COORD_BITS-1] &&
                   (x_ext < CMP_BITS'(screen_width_ff)) &&
                   (y_ext < CMP_BITS'(screen_height_ff));
      row        = screen_height_ff - DIM_BITS'(1) - y_ext[DIM_BITS-1:0];
      prod       = PROD_BITS'(row) * PROD_BITS'(screen_width_ff);
      index_full = (PROD_BITS + 1)'(prod) + (PROD_BITS + 1)'(x_ext[DIM_BITS-1:0]);
      index_clip = on_screen ? index_full[INDEX_BITS-1:0] : '0;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff        <= 1'b0;
         p1_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
      end else begin
         active_ff <= active_in;
         if (p1_advance) begin
            p1_valid_ff <= emit;
         end
         if (out_advance) begin
            out_valid_ff <= p1_valid_ff;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
               CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers. The line state is only read while a line is active,
   // and a start rewrites all of it, so it needs no reset.
   always_ff @(posedge clock) begin
      cur_x_ff       <= cur_x_in;
      cur_y_ff       <= cur_y_in;
      major_end_ff   <= major_end_in;
      error_ff       <= error_in;
      major_delta_ff <= major_delta_in;
      minor_delta_ff <= minor_delta_in;
      steep_ff       <= steep_in;
      minor_up_ff    <= minor_up_in;
      if (p1_advance && emit) begin
         p1_x_ff    <= cur_x_in;
         p1_y_ff    <= cur_y_in;
         p1_last_ff <= is_last;
      end
      if (out_advance && p1_valid_ff) begin
         out_x_ff     <= p1_x_ff;
         out_y_ff     <= p1_y_ff;
         out_on_ff    <= on_screen;
         out_index_ff <= index_clip;
         out_last_ff  <= p1_last_ff;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.pixel_x      = out_x_ff;
   assign rsp_bus.pixel_y      = out_y_ff;
   assign rsp_bus.on_screen    = out_on_ff;
   assign rsp_bus.buffer_index = out_index_ff;
   assign rsp_bus.last         = out_last_ff;

endmodule

FILE: hdl/brlg_checker.sv
module brlg_checker import brlg_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [COORD_BITS-1:0] pixel_x,
   input logic signed [COORD_BITS-1:0] pixel_y,
   input logic                         on_screen,
   input logic [INDEX_BITS-1:0]        buffer_index,
   input logic                         last
);

   // No pixel beat may appear right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("pixel beat right after reset");

   // A stalled pixel beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_x) && $stable(pixel_y) &&
      $stable(on_screen) && $stable(buffer_index) && $stable(last))
      else $error("stalled pixel beat changed");

   // A clipped pixel carries a zero index.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !on_screen |-> buffer_index == '0)
      else $error("clipped pixel with nonzero index");

   // A pixel on screen has no negative coordinate.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && on_screen |-> !pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1])
      else $error("negative coordinate marked on screen");

endmodule

bind bresenham_line_pixel_generator brlg_checker #(.COORD_BITS(COORD_BITS)) u_brlg_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .pixel_x      (rsp_bus.pixel_x),
   .pixel_y      (rsp_bus.pixel_y),
   .on_screen    (rsp_bus.on_screen),
   .buffer_index (rsp_bus.buffer_index),
   .last         (rsp_bus.last)
);

FILE: tb/line_pixel_checker.sv
module line_pixel_checker import brlg_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   brlg_req_if                       req_bus,
   brlg_rsp_if                       rsp_bus,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DIM_BITS-1:0]       csr_wdata,
   output int                        failures,
   output int                        pending_pixels
);

   // Past this many mismatches the count still grows but the log stays quiet.
   localparam int REPORT_LIMIT = 200;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type             x;
      coord_type             y;
      logic                  on_screen;
      logic [INDEX_BITS-1:0] index;
      logic                  last;
   } pixel_type;

   logic [DIM_BITS-1:0] width;
   logic [DIM_BITS-1:0] height;

   // Line walker state, kept in plain integers.
   int pen_x;
   int pen_y;
   int major_stop;
   int err;
   int major_len;
   int minor_len;
   bit steep;
   bit minor_up;
   bit drawing;

   pixel_type pixel_q[$];
   pixel_type expected_pixel;
   pixel_type seen_pixel;
   int        fail_count;

   function automatic pixel_type make_pixel(bit done);
      pixel_type p;
      p.x         = coord_type'(pen_x);
      p.y         = coord_type'(pen_y);
      p.on_screen = pen_x >= 0 && pen_y >= 0 && pen_x < int'(width) && pen_y < int'(height);
      p.index     = p.on_screen ?
                    INDEX_BITS'((int'(height) - 1 - pen_y) * int'(width) + pen_x) : '0;
      p.last      = done;
      return p;
   endfunction

   task automatic apply_command(cmd_type cmd, coord_type sx, coord_type sy,
                                coord_type ex, coord_type ey);
      int dx;
      int dy;
      int adx;
      int ady;
      bit done;
      if (cmd == CMD_START) begin
         dx       = int'(ex) - int'(sx);
         dy       = int'(ey) - int'(sy);
         adx      = dx < 0 ? -dx : dx;
         ady      = dy < 0 ? -dy : dy;
         minor_up = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
         steep    = ady > adx;
         if (!steep) begin
            major_len = adx;
            minor_len = ady;
            if (dx >= 0) begin
               pen_x = sx; pen_y = sy; major_stop = ex;
            end else begin
               pen_x = ex; pen_y = ey; major_stop = sx;
            end
            done = pen_x >= major_stop;
         end else begin
            major_len = ady;
            minor_len = adx;
            if (dy >= 0) begin
               pen_x = sx; pen_y = sy; major_stop = ey;
            end else begin
               pen_x = ex; pen_y = ey; major_stop = sy;
            end
            done = pen_y >= major_stop;
         end
         err = 2 * minor_len - major_len;
      end else begin
         if (!drawing) return;
         // Shallow lines step the minor axis on err >= 0, steep ones only on err > 0.
         if (!steep) begin
            pen_x += 1;
            if (err < 0) begin
               err += 2 * minor_len;
            end else begin
               pen_y += minor_up ? 1 : -1;
               err += 2 * (minor_len - major_len);
            end
            done = pen_x >= major_stop;
         end else begin
            pen_y += 1;
            if (err <= 0) begin
               err += 2 * minor_len;
            end else begin
               pen_x += minor_up ? 1 : -1;
               err += 2 * (minor_len - major_len);
            end
            done = pen_y >= major_stop;
         end
      end
      drawing = !done;
      pixel_q.push_back(make_pixel(done));
   endtask

   task automatic check_field(string field, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $error("%s: expected %0d, got %0d", field, $signed(expected), $signed(actual));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width  = SCREEN_WIDTH_RESET;
         height = SCREEN_HEIGHT_RESET;
         pen_x = 0; pen_y = 0; major_stop = 0; err = 0;
         major_len = 0; minor_len = 0;
         steep = 0; minor_up = 0; drawing = 0;
         pixel_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SCREEN_WIDTH:  width  = csr_wdata;
               CSR_SCREEN_HEIGHT: height = csr_wdata;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready)
            apply_command(cmd_type'(req_bus.command), req_bus.start_x, req_bus.start_y,
                          req_bus.end_x, req_bus.end_y);
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_pixel.x         = rsp_bus.pixel_x;
            seen_pixel.y         = rsp_bus.pixel_y;
            seen_pixel.on_screen = rsp_bus.on_screen;
            seen_pixel.index     = rsp_bus.buffer_index;
            seen_pixel.last      = rsp_bus.last;
            if (pixel_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $error("pixel beat with none expected: x %0d, y %0d",
                         seen_pixel.x, seen_pixel.y);
            end else begin
               expected_pixel = pixel_q.pop_front();
               check_field("pixel_x", 32'(expected_pixel.x), 32'(seen_pixel.x));
               check_field("pixel_y", 32'(expected_pixel.y), 32'(seen_pixel.y));
               check_field("on_screen", 32'(expected_pixel.on_screen),
                           32'(seen_pixel.on_screen));
               check_field("buffer_index", 32'(expected_pixel.index), 32'(seen_pixel.index));
               check_field("last", 32'(expected_pixel.last), 32'(seen_pixel.last));
            end
         end
      end
      pending_pixels <= pixel_q.size();
      failures       <= fail_count;
   end

endmodule

FILE: tb/tb.sv
module tb;
   import brlg_pkg::*;

   localparam int COORD_BITS = 12;
   localparam int COORD_MIN  = -(1 << (COORD_BITS - 1));
   localparam int COORD_MAX  = (1 << (COORD_BITS - 1)) - 1;

   // The block answers through stage one and the output register; the drain wait lets a
   // trailing step that produces nothing clear the pipeline.
   localparam int DRAIN_CYCLES     = 4;
   localparam int RESET_CYCLES     = 8;
   localparam int NUM_PHASES       = 8;
   localparam int PIXELS_PER_PHASE = 140;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANGE_LINE_STEPS = 150;
   // The longest honest gap without any beat is the long receiver hold-off;
   // the watchdog allows several times that.
   localparam int WATCHDOG_LIMIT   = 2000;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [DIM_BITS-1:0]       csr_wdata;

   int failures;
   int pending_pixels;

   // Knobs for the command driver (idle rate) and the pixel receiver (stall rate and hold-off).
   int send_idle_pct;
   int rsp_stall_pct;
   bit hold_request;

   // Screen size currently programmed, used to aim lines at the visible area.
   int screen_w;
   int screen_h;
   int pixels_sent;
   int quiet_cycles;

   brlg_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
   brlg_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_bus ();

   bresenham_line_pixel_generator #(.COORD_BITS(COORD_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   line_pixel_checker #(.COORD_BITS(COORD_BITS)) pixel_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .failures       (failures),
      .pending_pixels (pending_pixels)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // The pixel receiver. Outside the one long hold-off it stalls at random at
   // the rate the current phase asks for. The hold-off is counted here, so the
   // command driver keeps offering beats until the block backs up.
   initial begin : pixel_receiver
      int held;
      held = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_request && held < LONG_HOLD_CYCLES) begin
            rsp_bus.ready <= 1'b0;
            held++;
         end else begin
            rsp_bus.ready <= rsp_stall_pct == 0 || $urandom_range(99) >= rsp_stall_pct;
         end
      end
   end

   // Any cycle with a beat on either channel counts as progress. A stretch
   // without one means the block has hung or a pixel never came.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic coord_type to_coord(int v);
      if (v < COORD_MIN)
         v = COORD_MIN;
      else if (v > COORD_MAX)
         v = COORD_MAX;
      return coord_type'(v);
   endfunction

   // A line origin: half the time anywhere in the coordinate range, otherwise
   // in or just around the screen so that clipping edges get hit often.
   function automatic int pick_base(int dim);
      int lim;
      lim = dim > COORD_MAX ? COORD_MAX : dim;
      if ($urandom_range(1) == 0)
         return int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
      return int'($urandom_range(0, lim + 16)) - 8;
   endfunction

   // One command beat. Idle cycles go in front of it, so that valid stays
   // high across back to back beats.
   task automatic send_command(cmd_type cmd, coord_type sx, coord_type sy,
                               coord_type ex, coord_type ey);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= cmd;
      req_bus.start_x <= sx;
      req_bus.start_y <= sy;
      req_bus.end_x   <= ex;
      req_bus.end_y   <= ey;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   // A start beat followed by a number of step beats. Steps carry junk
   // coordinates, which the block must ignore. More steps than the line has
   // pixels after its first exercise steps with no line in progress; fewer
   // leave the line to be dropped by the next start.
   task automatic run_line(coord_type sx, coord_type sy, coord_type ex, coord_type ey,
                           int steps);
      int adx;
      int ady;
      int span;
      adx  = int'(ex) - int'(sx);
      ady  = int'(ey) - int'(sy);
      adx  = adx < 0 ? -adx : adx;
      ady  = ady < 0 ? -ady : ady;
      span = adx > ady ? adx : ady;
      send_command(CMD_START, sx, sy, ex, ey);
      for (int i = 0; i < steps; i++)
         send_command(CMD_STEP, coord_type'($urandom), coord_type'($urandom),
                      coord_type'($urandom), coord_type'($urandom));
      pixels_sent += 1 + (steps < span ? steps : span);
   endtask

   // Mostly short lines walked to their end, some medium ones, and a few with
   // endpoints anywhere in the range that get cut short.
   task automatic random_line();
      int        roll;
      int        reach;
      int        bx;
      int        by;
      int        adx;
      int        ady;
      int        span;
      int        steps;
      bit        wild;
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
      roll = $urandom_range(99);
      wild = roll < 5;
      if (wild) begin
         sx = coord_type'($urandom);
         sy = coord_type'($urandom);
         ex = coord_type'($urandom);
         ey = coord_type'($urandom);
      end else begin
         reach = roll < 20 ? 150 : 12;
         bx = pick_base(screen_w);
         by = pick_base(screen_h);
         sx = to_coord(bx);
         sy = to_coord(by);
         ex = to_coord(bx + int'($urandom_range(0, 2 * reach)) - reach);
         ey = to_coord(by + int'($urandom_range(0, 2 * reach)) - reach);
      end
      adx  = int'(ex) - int'(sx);
      ady  = int'(ey) - int'(sy);
      adx  = adx < 0 ? -adx : adx;
      ady  = ady < 0 ? -ady : ady;
      span = adx > ady ? adx : ady;
      roll = $urandom_range(99);
      if (roll < 75)
         steps = span;
      else if (roll < 85)
         steps = span + int'($urandom_range(1, 3));
      else
         steps = span == 0 ? 0 : int'($urandom_range(0, span - 1));
      if (wild && steps > 30)
         steps = int'($urandom_range(0, 30));
      run_line(sx, sy, ex, ey, steps);
   endtask

   // Stop offering commands and wait until every predicted pixel has come
   // back, then let a possible trailing step leave the pipeline.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_screen_size(int w, int h);
      csr_we    <= 1'b1;
      csr_index <= CSR_SCREEN_WIDTH;
      csr_wdata <= DIM_BITS'(w);
      @(posedge clock);
      csr_index <= CSR_SCREEN_HEIGHT;
      csr_wdata <= DIM_BITS'(h);
      @(posedge clock);
      csr_we    <= 1'b0;
      screen_w = w;
      screen_h = h;
   endtask

   initial begin : stimulus
      int phase_goal;
      int new_w;
      int new_h;

      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.command <= CMD_STEP;
      req_bus.start_x <= '0;
      req_bus.start_y <= '0;
      req_bus.end_x   <= '0;
      req_bus.end_y   <= '0;
      csr_we          <= 1'b0;
      csr_index       <= CSR_SCREEN_WIDTH;
      csr_wdata       <= '0;
      rsp_stall_pct   <= 0;
      hold_request    <= 1'b0;
      send_idle_pct = 0;
      screen_w      = int'(SCREEN_WIDTH_RESET);
      screen_h      = int'(SCREEN_HEIGHT_RESET);
      pixels_sent   = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed lines on the reset screen of 700 by 700, no idling.
      // A step right after reset has no line to advance and yields nothing.
      send_command(CMD_STEP, coord_type'(-1), coord_type'(-1), coord_type'(-1),
                   coord_type'(-1));
      // Zero-length line at the far corner of the range, then a stray step.
      run_line(coord_type'(COORD_MAX), coord_type'(COORD_MIN),
               coord_type'(COORD_MAX), coord_type'(COORD_MIN), 1);
      // Full-range diagonal, dropped after two steps by the next start.
      run_line(coord_type'(COORD_MIN), coord_type'(COORD_MIN),
               coord_type'(COORD_MAX), coord_type'(COORD_MAX), 2);
      // Shallow line whose first error term is exactly zero: the minor axis moves.
      run_line(coord_type'(0), coord_type'(0), coord_type'(2), coord_type'(1), 2);
      // Shallow line given right to left, drawn from the other end going down.
      run_line(coord_type'(4), coord_type'(1), coord_type'(0), coord_type'(3), 4);
      // Steep line with a zero first error term: the minor axis holds.
      run_line(coord_type'(1), coord_type'(2), coord_type'(0), coord_type'(0), 2);
      // Equal deltas count as shallow; the minor step is downward.
      run_line(coord_type'(0), coord_type'(0), coord_type'(2), coord_type'(-2), 2);
      // Crossing the right edge of the screen near its top row.
      run_line(coord_type'(698), coord_type'(699), coord_type'(700), coord_type'(698), 2);

      // Each phase programs a screen size and an idling pattern. Zero sizes
      // put every pixel off screen; the largest size makes the index wrap.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase != 0) begin
            wait_drained();
            case (phase)
               1: begin new_w = 1;    new_h = 1;    end
               2: begin new_w = 0;    new_h = 700;  end
               3: begin new_w = 700;  new_h = 0;    end
               4: begin new_w = 4095; new_h = 4095; end
               5: begin new_w = 2048; new_h = 2048; end
               6: begin
                  new_w = int'($urandom_range(1, 4095));
                  new_h = int'($urandom_range(1, 4095));
               end
               default: begin new_w = 640; new_h = 480; end
            endcase
            write_screen_size(new_w, new_h);
         end
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin send_idle_pct = 63; rsp_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct <= 63; end
            default: begin send_idle_pct = 7; rsp_stall_pct <= 7; end
         endcase
         // The receiver holds off once for a long stretch while commands keep
         // coming, so the block fills up and stalls its command channel.
         if (phase == 2)
            hold_request <= 1'b1;
         // One line spanning almost the whole range on both axes, walked for
         // a stretch on the largest screen and then dropped by the next start.
         if (phase == 4)
            run_line(coord_type'(COORD_MIN), coord_type'(COORD_MAX),
                     coord_type'(COORD_MAX), coord_type'(-2000), RANGE_LINE_STEPS);
         phase_goal = pixels_sent + PIXELS_PER_PHASE;
         while (pixels_sent < phase_goal)
            random_line();
      end

      wait_drained();
      if (failures == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: files.f
hdl/brlg_pkg.sv
hdl/brlg_if.sv
hdl/bresenham_line_pixel_generator.sv
hdl/brlg_checker.sv
tb/line_pixel_checker.sv
tb/tb.sv
